// File: sv/spl_pkg.sv
// package for the stereo peak limiter: shared widths, register reset values,
// register index codes and the structs passed between the limiter modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spl_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ENV_W     = 24;
   localparam int REG_W     = 16;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int DIV_STEPS = 17;

   // 0.95 in q0.16
   localparam logic [REG_W-1:0] GAIN_095      = 16'd62259;
   localparam logic [REG_W-1:0] LIMIT_RESET   = 16'd16384;
   localparam logic [REG_W-1:0] ATTACK_RESET  = 16'd655;
   localparam logic [REG_W-1:0] RELEASE_RESET = 16'd655;

   typedef enum logic [1:0] {
      REG_LIMIT   = 2'd0,
      REG_ATTACK  = 2'd1,
      REG_RELEASE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [REG_W-1:0] limit_level;
      logic [REG_W-1:0] attack_coef;
      logic [REG_W-1:0] release_coef;
   } csr_regs_type;

   typedef struct packed {
      logic                    start;
      logic signed [ENV_W-1:0] num;
      logic signed [ENV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic signed [SAMPLE_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: sv/spl_if.sv
// valid/ready channel interfaces for the sample pair input and the limited output
// depends on spl_pkg for the sample width
`timescale 1ns / 1ps
`default_nettype none

interface spl_req_if import spl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface spl_rsp_if import spl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

// File: sv/stereo_peak_limiter_unit.sv
// stereo peak limiter top: sequencer around one shared multiplier, envelope
// follower and the iterative divider; depends on spl_pkg, spl_if, spl_csr, spl_div
//
//  channel   direction  handshake          payload
//  req_ch    in         valid / ready      left_sample, right_sample (q1.15)
//  rsp_ch    out        valid / ready      left_out, right_out (q1.15, saturated)
//  apb       in         psel/penable/...   limit_level, attack_coef, release_coef
//
// one word is taken only while the sequencer is idle; it then passes through the gain,
// scaling and envelope steps on the shared multiplier, the decision step and a final
// step that hands the result to the output register
// a limited word adds two divisions (start, 17 quotient bits, finish and hand-over),
// run one after the other on the one divider; a division whose dividend is zero or whose
// quotient overflows at once skips the quotient bits and goes straight to the finish
// reset is synchronous; the envelope clears to zero and registers to their defaults
// a finished word waits in the output register, and the next word is taken
// meanwhile; the sequencer only holds if that register is still full at the end
`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_limiter_unit import spl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   spl_req_if.sink                req_ch,
   spl_rsp_if.source              rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   localparam int PROD_W = 58;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_SCL_L,
      ST_SCL_R,
      ST_RND_R,
      ST_DRV,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_DECIDE,
      ST_DIV_L,
      ST_DIV_R,
      ST_DONE
   } seq_state_type;

   csr_regs_type regs;
   div_req_type  div_req_ff, div_req_in;
   div_rsp_type  div_rsp;

   seq_state_type              state_ff, state_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic [31:0]                gain_ff, gain_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ENV_W-1:0]    s0_ff, s0_in;
   logic signed [ENV_W-1:0]    s1_ff, s1_in;
   logic signed [ENV_W-1:0]    drive_ff, drive_in;
   logic [REG_W-1:0]           coef_ff, coef_in;
   logic signed [ENV_W-1:0]    env_ff, env_in;
   logic signed [ENV_W-1:0]    den_ff, den_in;
   logic signed [SAMPLE_W-1:0] res_l_ff, res_l_in;
   logic signed [SAMPLE_W-1:0] res_r_ff, res_r_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_l_in;
   logic signed [SAMPLE_W-1:0] rsp_r_ff, rsp_r_in;

   // shared multiplier
   logic signed [ENV_W:0]      mul_a;
   logic [31:0]                mul_b;
   logic signed [PROD_W-1:0]   mul_p;

   logic [PROD_W-1:0]          r24_sum;
   logic signed [ENV_W-1:0]    scaled_rnd;
   logic [40:0]                r16_sum;
   logic signed [ENV_W:0]      env_adj;
   logic signed [ENV_W:0]      env_diff;
   logic signed [ENV_W+1:0]    env_sum;
   logic signed [ENV_W-1:0]    env_next;
   logic signed [ENV_W-1:0]    drive_sel;
   logic [ENV_W-1:0]           env_mag;
   logic [ENV_W-1:0]           lim21;
   logic                       limiting;
   logic                       above_one;
   logic [ENV_W:0]             den_alt;
   logic signed [ENV_W-1:0]    den_sel;
   logic [ENV_W:0]             pass_l_sum;
   logic [ENV_W:0]             pass_r_sum;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 19'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   spl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   spl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // round to nearest, ties away from zero: bias is one less for negatives
   assign r24_sum    = prod_ff + (prod_ff[PROD_W-1] ? 58'd8388607 : 58'd8388608);
   assign scaled_rnd = $signed(r24_sum[47:24]);
   assign r16_sum    = prod_ff[40:0] + (prod_ff[PROD_W-1] ? 41'd32767 : 41'd32768);
   assign env_adj    = $signed(r16_sum[40:16]);
   assign env_diff   = {env_ff[ENV_W-1], env_ff} - {drive_ff[ENV_W-1], drive_ff};
   assign env_sum    = {{2{drive_ff[ENV_W-1]}}, drive_ff} + {env_adj[ENV_W], env_adj};
   assign drive_sel  = (s0_ff > s1_ff) ? s0_ff : s1_ff;

   always_comb begin
      if (env_sum > 26'sd8388607) begin
         env_next = 24'sh7fffff;
      end else if (env_sum < -26'sd8388608) begin
         env_next = 24'sh800000;
      end else begin
         env_next = env_sum[ENV_W-1:0];
      end
   end

   assign env_mag   = env_ff[ENV_W-1] ? (~env_ff + 1'b1) : env_ff;
   assign lim21     = {1'b0, regs.limit_level, 7'b0};
   assign limiting  = env_mag > lim21;
   assign above_one = env_mag > 24'h200000;
   // 1 + envelope - limit, with everything at 21 fraction bits
   assign den_alt   = 25'h0200000 + {env_ff[ENV_W-1], env_ff} - {1'b0, lim21};
   assign den_sel   = above_one ? env_ff : $signed(den_alt[ENV_W-1:0]);

   assign pass_l_sum = {s0_ff[ENV_W-1], s0_ff} + (s0_ff[ENV_W-1] ? 25'd31 : 25'd32);
   assign pass_r_sum = {s1_ff[ENV_W-1], s1_ff} + (s1_ff[ENV_W-1] ? 25'd31 : 25'd32);

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      drive_in     = drive_ff;
      coef_in      = coef_ff;
      env_in       = env_ff;
      den_in       = den_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               left_in  = req_ch.left_sample;
               right_in = req_ch.right_sample;
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            mul_a    = {9'b0, regs.limit_level};
            mul_b    = {16'b0, GAIN_095};
            gain_in  = mul_p[31:0];
            state_in = ST_SCL_L;
         end
         ST_SCL_L: begin
            mul_a    = {{9{left_ff[SAMPLE_W-1]}}, left_ff};
            mul_b    = gain_ff;
            prod_in  = mul_p;
            state_in = ST_SCL_R;
         end
         ST_SCL_R: begin
            s0_in    = scaled_rnd;
            mul_a    = {{9{right_ff[SAMPLE_W-1]}}, right_ff};
            mul_b    = gain_ff;
            prod_in  = mul_p;
            state_in = ST_RND_R;
         end
         ST_RND_R: begin
            s1_in    = scaled_rnd;
            state_in = ST_DRV;
         end
         ST_DRV: begin
            // a drive equal to the envelope counts as falling
            drive_in = drive_sel;
            coef_in  = (drive_sel > env_ff) ? regs.attack_coef : regs.release_coef;
            state_in = ST_ENV_MUL;
         end
         ST_ENV_MUL: begin
            mul_a    = env_diff;
            mul_b    = {16'b0, coef_ff};
            prod_in  = mul_p;
            state_in = ST_ENV_UPD;
         end
         ST_ENV_UPD: begin
            env_in   = env_next;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (limiting) begin
               den_in           = den_sel;
               div_req_in.start = 1'b1;
               div_req_in.num   = s0_ff;
               div_req_in.den   = den_sel;
               state_in         = ST_DIV_L;
            end else begin
               res_l_in = sat16($signed(pass_l_sum[ENV_W:6]));
               res_r_in = sat16($signed(pass_r_sum[ENV_W:6]));
               state_in = ST_DONE;
            end
         end
         ST_DIV_L: begin
            if (div_rsp.done) begin
               res_l_in         = div_rsp.quot;
               div_req_in.start = 1'b1;
               div_req_in.num   = s1_ff;
               div_req_in.den   = den_ff;
               state_in         = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (div_rsp.done) begin
               res_r_in = div_rsp.quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         env_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         env_ff           <= env_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
      end
      div_req_ff.num <= div_req_in.num;
      div_req_ff.den <= div_req_in.den;
      left_ff        <= left_in;
      right_ff       <= right_in;
      gain_ff        <= gain_in;
      prod_ff        <= prod_in;
      s0_ff          <= s0_in;
      s1_ff          <= s1_in;
      drive_ff       <= drive_in;
      coef_ff        <= coef_in;
      den_ff         <= den_in;
      res_l_ff       <= res_l_in;
      res_r_ff       <= res_r_in;
      rsp_l_ff       <= rsp_l_in;
      rsp_r_ff       <= rsp_r_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_l_ff;
   assign rsp_ch.right_out = rsp_r_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_DONE))
      else $error("output word raised outside the finishing step");

   a_env_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(env_ff)) |-> $past(state_ff == ST_ENV_UPD))
      else $error("envelope changed outside its update step");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_L || state_ff == ST_DIV_R))
      else $error("quotient arrived while no division was pending");

endmodule

`default_nettype wire

// File: sv/spl_csr.sv
// apb register bank: limit level, attack and release coefficients
// depends on spl_pkg
`timescale 1ns / 1ps
`default_nettype none

module spl_csr import spl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output csr_regs_type           regs
);

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   logic          wr_en;
   reg_index_type idx;

   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[CSR_AW-1:2]);
   assign pready = 1'b1;
   assign regs   = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (idx)
            REG_LIMIT:   regs_in.limit_level  = pwdata[REG_W-1:0];
            REG_ATTACK:  regs_in.attack_coef  = pwdata[REG_W-1:0];
            REG_RELEASE: regs_in.release_coef = pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_LIMIT:   prdata = {{(CSR_DW-REG_W){1'b0}}, regs_ff.limit_level};
         REG_ATTACK:  prdata = {{(CSR_DW-REG_W){1'b0}}, regs_ff.attack_coef};
         REG_RELEASE: prdata = {{(CSR_DW-REG_W){1'b0}}, regs_ff.release_coef};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.limit_level  <= LIMIT_RESET;
         regs_ff.attack_coef  <= ATTACK_RESET;
         regs_ff.release_coef <= RELEASE_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   a_limit_written: assert property (@(posedge clock) disable iff (reset)
      (wr_en && idx == REG_LIMIT) |=> (regs_ff.limit_level == $past(pwdata[REG_W-1:0])))
      else $error("limit level not taken from write data");

   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(regs_ff))
      else $error("register changed without a write");

   a_attack_only: assert property (@(posedge clock) disable iff (reset)
      (wr_en && idx == REG_ATTACK) |=>
         ($stable(regs_ff.limit_level) && $stable(regs_ff.release_coef)))
      else $error("attack write disturbed another register");

endmodule

`default_nettype wire

// File: sv/spl_div.sv
// shared iterative divider: (num * 2^15) / den, truncated toward zero,
// saturated to q1.15, one quotient bit a cycle; depends on spl_pkg
`timescale 1ns / 1ps
`default_nettype none

module spl_div import spl_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } div_state_type;

   div_state_type           state_ff, state_in;
   logic [ENV_W-1:0]        rem_ff, rem_in;
   logic [ENV_W-1:0]        den_mag_ff, den_mag_in;
   logic [DIV_STEPS-1:0]    low_ff, low_in;
   logic [DIV_STEPS-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;
   logic                    zero_ff, zero_in;
   logic                    done_ff, done_in;
   logic signed [SAMPLE_W-1:0] quot_ff, quot_in;

   logic [ENV_W-1:0]        num_mag;
   logic [ENV_W-1:0]        den_mag;
   logic [ENV_W:0]          rem_try;
   logic [ENV_W:0]          rem_sub;
   logic [SAMPLE_W-1:0]     quo_neg;

   assign num_mag = req.num[ENV_W-1] ? (~req.num + 1'b1) : req.num;
   assign den_mag = req.den[ENV_W-1] ? (~req.den + 1'b1) : req.den;
   assign rem_try = {rem_ff, low_ff[DIV_STEPS-1]};
   assign rem_sub = rem_try - {1'b0, den_mag_ff};
   assign quo_neg = ~quo_ff[SAMPLE_W-1:0] + 1'b1;

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      den_mag_in = den_mag_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      ovf_in     = ovf_ff;
      zero_in    = zero_ff;
      done_in    = 1'b0;
      quot_in    = quot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               // top bits of the shifted dividend go straight into the remainder
               rem_in     = {2'b00, num_mag[ENV_W-1:2]};
               low_in     = {num_mag[1:0], {(DIV_STEPS-2){1'b0}}};
               den_mag_in = den_mag;
               quo_in     = '0;
               cnt_in     = '0;
               neg_in     = req.num[ENV_W-1] ^ req.den[ENV_W-1];
               ovf_in     = {2'b00, num_mag[ENV_W-1:2]} >= den_mag;
               zero_in    = (num_mag == '0);
               state_in   = (num_mag == '0 || {2'b00, num_mag[ENV_W-1:2]} >= den_mag)
                            ? ST_FIN : ST_RUN;
            end
         end
         ST_RUN: begin
            if (rem_try >= {1'b0, den_mag_ff}) begin
               rem_in = rem_sub[ENV_W-1:0];
               quo_in = {quo_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in = rem_try[ENV_W-1:0];
               quo_in = {quo_ff[DIV_STEPS-2:0], 1'b0};
            end
            low_in = {low_ff[DIV_STEPS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS-1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            done_in  = 1'b1;
            state_in = ST_IDLE;
            if (zero_ff) begin
               quot_in = '0;
            end else if (ovf_ff) begin
               quot_in = neg_ff ? 16'sh8000 : 16'sh7fff;
            end else if (!neg_ff) begin
               quot_in = (quo_ff > 17'd32767) ? 16'sh7fff : $signed(quo_ff[SAMPLE_W-1:0]);
            end else begin
               quot_in = (quo_ff > 17'd32768) ? 16'sh8000 : $signed(quo_neg);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff     <= rem_in;
      den_mag_ff <= den_mag_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      ovf_ff     <= ovf_in;
      zero_ff    <= zero_in;
      quot_ff    <= quot_in;
   end

   assign rsp.busy = (state_ff != ST_IDLE);
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (state_ff == ST_IDLE))
      else $error("divider started while busy");

   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && done_ff) |-> $past(state_ff == ST_FIN))
      else $error("quotient flagged without finishing");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider ran past its last step");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// testbench for stereo_peak_limiter_unit: random stereo words with idle gaps and output stalls,
// limiter predictor and scoreboard in a class, register writes over the apb port
// depends on spl_pkg, spl_if and the limiter rtl
`timescale 1ns / 1ps

module tb_top;
   import spl_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } sample_pair_type;

   localparam logic [1:0] UNUSED_INDEX = 2'd3;
   localparam int         ENV_FRAC     = 21;
   localparam longint     ENV_ONE      = longint'(1) << ENV_FRAC;
   localparam longint     ENV_TOP      = (longint'(1) << (ENV_W - 1)) - 1;
   localparam longint     ENV_BOTTOM   = -(longint'(1) << (ENV_W - 1));
   localparam int         MAX_REPORTS  = 10;
   localparam int         CYCLE_LIMIT  = 900000;
   localparam int         TAIL_CYCLES  = 64;
   localparam int         PHASES       = 9;
   localparam int         PHASE_WORDS  = 110;

   class limited_pair_board;
      logic [REG_W-1:0]        limit_level;
      logic [REG_W-1:0]        attack_coef;
      logic [REG_W-1:0]        rel_coef;
      logic signed [ENV_W-1:0] envelope;
      sample_pair_type         expected_pairs[$];
      int                      mismatches;

      function new();
         limit_level = LIMIT_RESET;
         attack_coef = ATTACK_RESET;
         rel_coef    = RELEASE_RESET;
         envelope    = '0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_LIMIT:   limit_level = value[REG_W-1:0];
            REG_ATTACK:  attack_coef = value[REG_W-1:0];
            REG_RELEASE: rel_coef    = value[REG_W-1:0];
            default: ;
         endcase
      endfunction

      // round to nearest, ties away from zero
      function longint round_near(longint v, int sh);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + (longint'(1) << (sh - 1))) >>> sh;
         return (v < 0) ? -m : m;
      endfunction

      function logic signed [SAMPLE_W-1:0] sat_q15(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return SAMPLE_W'(v);
      endfunction

      function logic signed [SAMPLE_W-1:0] div_q15(longint num, longint den);
         if (den == 0) begin
            // zero divisor saturates toward the sign of the scaled sample
            if (num > 0) return 16'sh7fff;
            if (num < 0) return 16'sh8000;
            return '0;
         end
         return sat_q15((num * 32768) / den);
      endfunction

      // sample times 0.95 times limit, kept with 21 fraction bits
      function longint scale(logic signed [SAMPLE_W-1:0] s);
         return round_near(longint'(s) * longint'(limit_level) * longint'(GAIN_095), 24);
      endfunction

      function longint env_next(longint env, longint drive, longint coef);
         longint n;
         n = drive + round_near(coef * (env - drive), 16);
         if (n > ENV_TOP) n = ENV_TOP;
         if (n < ENV_BOTTOM) n = ENV_BOTTOM;
         return n;
      endfunction

      function sample_pair_type limit_pair(logic signed [SAMPLE_W-1:0] l, r);
         longint          s0, s1, drive, coef, env_new, lim21, mag, den;
         sample_pair_type res;
         s0 = scale(l);
         s1 = scale(r);
         drive = (s0 > s1) ? s0 : s1;
         // release applies when drive equals envelope
         coef = (drive > longint'(envelope)) ? longint'(attack_coef) : longint'(rel_coef);
         env_new = env_next(longint'(envelope), drive, coef);
         envelope = env_new[ENV_W-1:0];
         lim21 = longint'(limit_level) * 128;
         mag = (env_new < 0) ? -env_new : env_new;
         if (mag > lim21) begin
            den = (mag > ENV_ONE) ? env_new : ENV_ONE + env_new - lim21;
            res.left  = div_q15(s0, den);
            res.right = div_q15(s1, den);
         end else begin
            res.left  = sat_q15(round_near(s0, 6));
            res.right = sat_q15(round_near(s1, 6));
         end
         return res;
      endfunction

      function void note_input_pair(logic signed [SAMPLE_W-1:0] l, r);
         expected_pairs.push_back(limit_pair(l, r));
      endfunction

      function void check_output_pair(logic signed [SAMPLE_W-1:0] l, r);
         sample_pair_type want;
         if (expected_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected output word: left %0d right %0d", l, r);
            return;
         end
         want = expected_pairs.pop_front();
         if (l !== want.left || r !== want.right) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("output word mismatch: left %0d (exp %0d) right %0d (exp %0d)",
                        l, want.left, r, want.right);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   bit                steady_flow;
   int                cycle_count = 0;
   limited_pair_board board;

   spl_req_if req_ch ();
   spl_rsp_if rsp_ch ();

   stereo_peak_limiter_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stereo_peak_limiter_unit test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_output_pair(rsp_ch.left_out, rsp_ch.right_out);
   end

   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode);
      int mag;
      int corners [5] = '{-32768, 32767, 0, -1, 1};
      case (mode)
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
         2: begin
            // loud material, near full scale, pushes the envelope toward the limit
            mag = 32767 - int'($urandom_range(0, 2047));
            return SAMPLE_W'($urandom_range(0, 1) ? -mag - 1 : mag);
         end
         default: return SAMPLE_W'(corners[$urandom_range(0, 4)]);
      endcase
   endfunction

   // output stalls
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_pair(logic signed [SAMPLE_W-1:0] l, r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= l;
      req_ch.right_sample <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_input_pair(l, r);
   endtask

   task automatic drain(int settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.expected_pairs.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [CSR_DW-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // upper bits carry junk, they must be ignored
   task automatic write_config(logic [REG_W-1:0] lim, att, rel);
      csr_write(REG_LIMIT,   {16'($urandom), lim});
      csr_write(REG_ATTACK,  {16'($urandom), att});
      csr_write(REG_RELEASE, {16'($urandom), rel});
   endtask

   // park the envelope near -3.8, drop the limit to 0.25 and pick a sample and
   // attack value that land the envelope on limit - 1, so 1 + env - limit is zero
   task automatic aim_zero_divisor();
      longint                     target, env, d, c;
      int                         x, k;
      bit                         found;
      logic signed [SAMPLE_W-1:0] hit_sample;
      logic [REG_W-1:0]           hit_coef;
      write_config(16'hffff, 16'h0000, 16'h0000);
      send_pair(16'sh8000, 16'sh8000);
      drain(4);
      csr_write(REG_LIMIT, {16'($urandom), 16'd4096});
      target = longint'(4096) * 128 - ENV_ONE;
      env = longint'(board.envelope);
      found = 1'b0;
      hit_sample = '0;
      hit_coef = '0;
      for (x = 32767; x >= -32768 && !found; x--) begin
         d = board.scale(SAMPLE_W'(x));
         if (d > env) begin
            c = ((target - d) * 65536) / (env - d);
            for (k = -1; k <= 1; k++) begin
               if (!found && c + k >= 0 && c + k <= 65535 &&
                   board.env_next(env, d, c + k) == target) begin
                  found = 1'b1;
                  hit_sample = SAMPLE_W'(x);
                  hit_coef = REG_W'(c + k);
               end
            end
         end
      end
      if (found) begin
         csr_write(REG_ATTACK, {16'($urandom), hit_coef});
         send_pair(hit_sample, 16'sh8000);
      end
   endtask

   initial begin
      int phase, count, mode, run;
      board = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.left_sample = '0;
      req_ch.right_sample = '0;
      steady_flow = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, drive equal to envelope first
      send_pair(16'sh0000, 16'sh0000);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'sh8000, 16'sh7fff);
      send_pair(16'sh0001, -16'sh0001);
      send_pair(16'sh5555, 16'shaaaa);
      send_pair(-16'sh0001, 16'sh0000);
      drain(4);

      aim_zero_divisor();
      drain(4);

      // envelope above one but under the limit, so the words pass without a division
      write_config(16'hffff, 16'h0000, 16'hffff);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'sh0000, 16'sh4000);

      for (phase = 0; phase < PHASES; phase++) begin
         drain(4);
         steady_flow = (phase % 3 == 1);
         case (phase)
            0: write_config(16'd0, 16'($urandom), 16'($urandom));
            1: write_config(16'hffff, 16'hffff, 16'hffff);
            2: write_config(16'hffff, 16'h0000, 16'h0000);
            3: write_config(16'($urandom_range(0, 8191)), 16'($urandom), 16'($urandom));
            default: write_config(16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         if (phase == 4) csr_write(UNUSED_INDEX, $urandom);
         count = 0;
         while (count < PHASE_WORDS) begin
            mode = $urandom_range(0, 3);
            run = $urandom_range(5, 40);
            repeat (run) begin
               send_pair(pick_sample(mode), pick_sample(mode));
               count++;
            end
         end
      end

      drain(TAIL_CYCLES);
      if (board.mismatches == 0)
         $display("stereo_peak_limiter_unit test passed");
      else
         $display("stereo_peak_limiter_unit test failed");
      $finish;
   end

endmodule
